// ----- hdl/decimal_text_to_integer_unit_assert.svh -----
// Assertion macros for the decimal text to integer unit.
// Included by the top level; needs nothing else.
`ifndef DECIMAL_TEXT_TO_INTEGER_UNIT_ASSERT_SVH
`define DECIMAL_TEXT_TO_INTEGER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DTOI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtoi assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define DTOI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtoi assertion failed: next-cycle implication");

`endif

// ----- hdl/dtoi_pkg.sv -----
// Shared types and constants for the decimal text to integer unit.
// No dependencies.
package dtoi_pkg;

   typedef struct packed {
      logic [7:0] character;
      logic       last_char;
   } req_payload_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic               error;
   } rsp_payload_type;

   // Register indexes on the configuration port
   localparam logic CsrWideMode = 1'b0;
   localparam logic CsrTruncate = 1'b1;

   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharUpperL = 8'h4C;
   localparam logic [7:0] CharLowerL = 8'h6C;

   localparam logic [4:0] NarrowDigits = 5'd10;
   localparam logic [4:0] WideDigits   = 5'd19;

   localparam logic [63:0] NarrowPosMax = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] NarrowNegMax = 64'h0000_0000_8000_0000;
   localparam logic [63:0] WidePosMax   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] WideNegMax   = 64'h8000_0000_0000_0000;

endpackage

// ----- hdl/decimal_text_to_integer_unit.sv -----
// A final character's result reaches rsp via the input register, then the result
// register; a final character waits in the input register while rsp is stalled.
// One character per cycle unless a final character is held; the bounding loop is
// the magnitude times ten plus digit update, computed from the input register.
// Synchronous reset clears the pipeline, string state and both mode registers.
`include "decimal_text_to_integer_unit_assert.svh"

module decimal_text_to_integer_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  dtoi_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output dtoi_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic                      csr_write_data
);

   logic wide_mode_ff;
   logic truncate_ff;

   logic                      stage_valid_ff, stage_valid_in;
   dtoi_pkg::req_payload_type stage_data_ff;

   logic [63:0] magnitude_ff, magnitude_in;
   logic        negative_ff, negative_in;
   logic [4:0]  count_ff, count_in;
   logic        bad_ff, bad_in;
   logic        stopped_ff, stopped_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   dtoi_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic        out_free;
   logic        stage_fire;
   logic        req_accept;
   logic [7:0]  ch;
   logic        is_minus;
   logic        is_suffix;
   logic        is_digit;
   logic [4:0]  limit;
   logic        at_limit;
   logic [63:0] mag_step;
   logic [63:0] lim_pos;
   logic [63:0] lim_neg;
   logic        final_err;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign stage_fire = stage_valid_ff && (!stage_data_ff.last_char || out_free);
   assign req_stall  = stage_valid_ff && !stage_fire;
   assign req_accept = req_valid && !req_stall;

   assign ch        = stage_data_ff.character;
   assign is_minus  = (ch == dtoi_pkg::CharMinus);
   assign is_suffix = wide_mode_ff && stage_data_ff.last_char &&
                      ((ch == dtoi_pkg::CharUpperL) || (ch == dtoi_pkg::CharLowerL));
   assign is_digit  = (ch >= dtoi_pkg::CharZero) && (ch <= dtoi_pkg::CharNine);
   assign limit     = wide_mode_ff ? dtoi_pkg::WideDigits : dtoi_pkg::NarrowDigits;
   assign at_limit  = (count_ff >= limit);
   // times ten as shift-add; at most 19 digits so no wrap
   assign mag_step  = (magnitude_ff << 3) + (magnitude_ff << 1) + {60'd0, ch[3:0]};
   assign lim_pos   = wide_mode_ff ? dtoi_pkg::WidePosMax : dtoi_pkg::NarrowPosMax;
   assign lim_neg   = wide_mode_ff ? dtoi_pkg::WideNegMax : dtoi_pkg::NarrowNegMax;

   always_comb begin
      magnitude_in = magnitude_ff;
      negative_in  = negative_ff;
      count_in     = count_ff;
      bad_in       = bad_ff;
      stopped_in   = stopped_ff;
      final_err    = 1'b0;
      rsp_data_in  = rsp_data_ff;
      stage_valid_in = stage_valid_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      if (stage_fire) begin
         priority if (bad_ff || stopped_ff) begin
            // drop the rest of the string
         end else if (is_minus) begin
            negative_in  = 1'b1;
            magnitude_in = '0;
         end else if (is_suffix) begin
            // drop the suffix
         end else if (at_limit) begin
            if (wide_mode_ff && truncate_ff) begin
               stopped_in = 1'b1;
            end else begin
               bad_in = 1'b1;
            end
         end else if (!is_digit) begin
            bad_in = 1'b1;
         end else begin
            magnitude_in = mag_step;
            count_in     = 5'(count_ff + 5'd1);
         end

         if (stage_data_ff.last_char) begin
            if (negative_in) begin
               final_err = bad_in || (magnitude_in == '0) || (magnitude_in > lim_neg);
            end else begin
               final_err = bad_in || (magnitude_in > lim_pos);
            end
            rsp_data_in.error = final_err;
            if (final_err) begin
               rsp_data_in.value = '0;
            end else if (negative_in) begin
               rsp_data_in.value = $signed(64'(-magnitude_in));
            end else begin
               rsp_data_in.value = $signed(magnitude_in);
            end
            rsp_valid_in = 1'b1;
            // clear string state for the next transaction
            magnitude_in = '0;
            negative_in  = 1'b0;
            count_in     = '0;
            bad_in       = 1'b0;
            stopped_in   = 1'b0;
         end
      end

      if (req_accept) begin
         stage_valid_in = 1'b1;
      end else if (stage_fire) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_mode_ff   <= 1'b0;
         truncate_ff    <= 1'b0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         magnitude_ff   <= '0;
         negative_ff    <= 1'b0;
         count_ff       <= '0;
         bad_ff         <= 1'b0;
         stopped_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               dtoi_pkg::CsrWideMode: wide_mode_ff <= csr_write_data;
               dtoi_pkg::CsrTruncate: truncate_ff  <= csr_write_data;
               default:               wide_mode_ff <= wide_mode_ff;
            endcase
         end
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         magnitude_ff   <= magnitude_in;
         negative_ff    <= negative_in;
         count_ff       <= count_in;
         bad_ff         <= bad_in;
         stopped_ff     <= stopped_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_data_ff <= req_payload;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   `DTOI_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= dtoi_pkg::WideDigits)
   `DTOI_ASSERT_IMPLY(a_err_zero, clock, reset,
      rsp_valid_ff && rsp_data_ff.error, rsp_data_ff.value == '0)
   `DTOI_ASSERT_NEXT(a_last_gives_rsp, clock, reset,
      stage_fire && stage_data_ff.last_char, rsp_valid_ff)
   `DTOI_ASSERT_NEXT(a_last_clears, clock, reset, stage_fire && stage_data_ff.last_char,
      (count_ff == '0) && !negative_ff && !bad_ff && !stopped_ff)

endmodule
